// ===== rtl/core/odf_pkg.sv =====
// ----------------------------------------------------------------------------
// odf_pkg
// Shared widths, stream layout and helper functions for the operator
// dominance filter.
// ----------------------------------------------------------------------------
`default_nettype none

package odf_pkg;

	localparam int DEF_MAX_OPS   = 64;
	localparam int DEF_MAX_PRE   = 5;
	localparam int DEF_PROP_BITS = 16;

	localparam int IN_PROP_W = 16;
	localparam int CNT_W     = 3;
	localparam int COST_W    = 31;
	localparam int OUT_IDX_W = 6;

	// input beat layout
	localparam int IN_CNT_LSB  = 16;
	localparam int IN_PRE_LSB  = 19;
	localparam int IN_COST_LSB = 99;
	localparam int IN_DATA_W   = 136;
	localparam int OUT_DATA_W  = 8;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic int prop_w(input int prop_bits);
		return (prop_bits < IN_PROP_W) ? prop_bits : IN_PROP_W;
	endfunction

	// stored record: effect, preconditions, count, cost (lowest first)
	function automatic int store_w(input int max_pre, input int pw);
		return pw + max_pre * pw + CNT_W + COST_W;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/odf_front.sv =====
// ----------------------------------------------------------------------------
// odf_front
// Input side: takes beats, masks ids, clears unused preconditions and
// packs a record for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module odf_front #(
	parameter int MAX_PRE   = odf_pkg::DEF_MAX_PRE,
	parameter int PROP_BITS = odf_pkg::DEF_PROP_BITS,
	localparam int PW       = odf_pkg::prop_w(PROP_BITS),
	localparam int REC_W    = odf_pkg::store_w(MAX_PRE, PW) + 1
) (
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// effect_id, pre_count, pre_a, pre_b, pre_c, pre_d, pre_e, op_cost
	input  wire logic [odf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                           s_axis_tlast,
	input  wire odf_pkg::q_status_t             q_status,
	output logic                                q_push,
	output logic [REC_W-1:0]                    q_wdata
);

	logic [odf_pkg::CNT_W-1:0]    cnt;
	logic [MAX_PRE-1:0][PW-1:0]   pre;
	logic                         testable;

	assign cnt      = s_axis_tdata[odf_pkg::IN_CNT_LSB +: odf_pkg::CNT_W];
	assign testable = cnt <= odf_pkg::CNT_W'(MAX_PRE);

	always_comb begin
		for (int i = 0; i < MAX_PRE; i++) begin
			if (testable && (odf_pkg::CNT_W'(i) < cnt)) begin
				pre[i] = s_axis_tdata[odf_pkg::IN_PRE_LSB + i * odf_pkg::IN_PROP_W +: PW];
			end else begin
				pre[i] = '0;
			end
		end
	end

	assign q_wdata = {s_axis_tlast,
		s_axis_tdata[odf_pkg::IN_COST_LSB +: odf_pkg::COST_W],
		cnt, pre, s_axis_tdata[PW-1:0]};

	assign s_axis_tready = !q_status.full;
	assign q_push        = s_axis_tvalid && !q_status.full;

endmodule

`default_nettype wire

// ===== rtl/core/odf_fifo.sv =====
// ----------------------------------------------------------------------------
// odf_fifo
// Short first-word-fall-through queue between the input side and the
// evaluation engine.
// ----------------------------------------------------------------------------
`default_nettype none

module odf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = odf_pkg::FIFO_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 pop,
	output logic [W-1:0]              rdata,
	output odf_pkg::q_status_t        status
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign status.full  = cnt_q == CW'(DEPTH);
	assign status.empty = cnt_q == '0;
	assign rdata        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/odf_back.sv =====
// ----------------------------------------------------------------------------
// odf_back
// Evaluation engine: stores operators, then scans each stored operator
// against all others through one read port and emits keep/drop beats.
// ----------------------------------------------------------------------------
`default_nettype none

module odf_back #(
	parameter int MAX_OPS   = odf_pkg::DEF_MAX_OPS,
	parameter int MAX_PRE   = odf_pkg::DEF_MAX_PRE,
	parameter int PROP_BITS = odf_pkg::DEF_PROP_BITS,
	localparam int PW       = odf_pkg::prop_w(PROP_BITS),
	localparam int STORE_W  = odf_pkg::store_w(MAX_PRE, PW),
	localparam int REC_W    = STORE_W + 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire odf_pkg::q_status_t              q_status,
	input  wire logic [REC_W-1:0]                q_rdata,
	output logic                                 q_pop,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// op_index, kept, overflowed
	output logic [odf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                 m_axis_tlast
);

	localparam int IW       = $clog2(MAX_OPS);
	localparam int NW       = $clog2(MAX_OPS + 1);
	localparam int CW       = odf_pkg::CNT_W;
	localparam int PRE_LSB  = PW;
	localparam int CNT_LSB  = PW + MAX_PRE * PW;
	localparam int COST_LSB = CNT_LSB + CW;
	localparam int NM       = MAX_PRE * MAX_PRE;

	typedef enum logic [2:0] {
		ST_LOAD, ST_RD_O, ST_CAP_O, ST_SCAN, ST_EMIT
	} state_t;

	state_t state_q;

	logic [STORE_W-1:0] mem_q [MAX_OPS];
	logic [STORE_W-1:0] rd_q;
	logic [IW-1:0]      rd_addr;

	logic [NW-1:0]      n_q;
	logic               ovf_q;
	logic [IW-1:0]      o_q;
	logic [NW-1:0]      p_q;

	logic [PW-1:0]              o_eff_q;
	logic [MAX_PRE-1:0][PW-1:0] o_pre_q;
	logic [CW-1:0]              o_cnt_q;
	logic [odf_pkg::COST_W-1:0] o_cost_q;

	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic          vld_s2;
	logic [NM-1:0] eq_s2;
	logic [CW-1:0] cnt_s2;
	logic          eff_eq_s2;
	logic          cost_lt_s2;
	logic          cost_eq_s2;
	logic          idx_lt_s2;
	logic          self_s2;

	logic          dom_q;

	logic [odf_pkg::OUT_IDX_W-1:0] out_idx_q;
	logic                          out_kept_q;
	logic                          out_ovf_q;
	logic                          out_last_q;

	logic               issue;
	logic               q_last;
	logic               store_full;
	logic               o_final;
	logic               out_free;
	logic [NM-1:0]      eq_c;
	logic               sub_c;
	logic               sup_c;
	logic               row_c;
	logic               col_c;
	logic               hit_c;

	assign q_last     = q_rdata[STORE_W];
	assign store_full = n_q == NW'(MAX_OPS);
	assign q_pop      = (state_q == ST_LOAD) && !q_status.empty;
	assign issue      = (state_q == ST_SCAN) && (p_q != n_q);
	assign rd_addr    = (state_q == ST_RD_O) ? o_q : p_q[IW-1:0];
	assign o_final    = (NW'(o_q) + NW'(1)) == n_q;
	assign out_free   = !m_axis_tvalid || m_axis_tready;

	// operator store
	always_ff @(posedge clk) begin
		if (q_pop && !store_full) begin
			mem_q[n_q[IW-1:0]] <= q_rdata[STORE_W-1:0];
		end
		rd_q <= mem_q[rd_addr];
	end

	// compare stage: raw precondition matches, effect match, cost and index order
	always_comb begin
		for (int i = 0; i < MAX_PRE; i++) begin
			for (int j = 0; j < MAX_PRE; j++) begin
				eq_c[i * MAX_PRE + j] = rd_q[PRE_LSB + i * PW +: PW] == o_pre_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		eq_s2      <= eq_c;
		cnt_s2     <= rd_q[CNT_LSB +: CW];
		eff_eq_s2  <= rd_q[PW-1:0] == o_eff_q;
		cost_lt_s2 <= rd_q[COST_LSB +: odf_pkg::COST_W] < o_cost_q;
		cost_eq_s2 <= rd_q[COST_LSB +: odf_pkg::COST_W] == o_cost_q;
		idx_lt_s2  <= idx_s1 < o_q;
		self_s2    <= idx_s1 == o_q;
		idx_s1     <= p_q[IW-1:0];
	end

	// decide stage: subset tests over the match matrix and the dominance decision
	always_comb begin
		sub_c = 1'b1;
		sup_c = 1'b1;
		row_c = 1'b0;
		col_c = 1'b0;
		for (int i = 0; i < MAX_PRE; i++) begin
			row_c = 1'b0;
			for (int j = 0; j < MAX_PRE; j++) begin
				if ((CW'(j) < o_cnt_q) && eq_s2[i * MAX_PRE + j]) begin
					row_c = 1'b1;
				end
			end
			if ((CW'(i) < cnt_s2) && !row_c) begin
				sub_c = 1'b0;
			end
		end
		for (int j = 0; j < MAX_PRE; j++) begin
			col_c = 1'b0;
			for (int i = 0; i < MAX_PRE; i++) begin
				if ((CW'(i) < cnt_s2) && eq_s2[i * MAX_PRE + j]) begin
					col_c = 1'b1;
				end
			end
			if ((CW'(j) < o_cnt_q) && !col_c) begin
				sup_c = 1'b0;
			end
		end
		hit_c = vld_s2 && (cnt_s2 <= CW'(MAX_PRE)) && !self_s2 && eff_eq_s2 && sub_c &&
			(sup_c ? (cost_lt_s2 || (cost_eq_s2 && idx_lt_s2)) : (cost_lt_s2 || cost_eq_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dom_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (state_q == ST_CAP_O) begin
				dom_q <= 1'b0;
			end else if (hit_c) begin
				dom_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CAP_O) begin
			o_eff_q  <= rd_q[PW-1:0];
			o_pre_q  <= rd_q[PRE_LSB +: MAX_PRE * PW];
			o_cnt_q  <= rd_q[CNT_LSB +: CW];
			o_cost_q <= rd_q[COST_LSB +: odf_pkg::COST_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			n_q           <= '0;
			ovf_q         <= 1'b0;
			o_q           <= '0;
			p_q           <= '0;
			m_axis_tvalid <= 1'b0;
			out_idx_q     <= '0;
			out_kept_q    <= 1'b0;
			out_ovf_q     <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (m_axis_tready && (state_q != ST_EMIT)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							n_q <= n_q + NW'(1);
						end
						if (q_last) begin
							o_q     <= '0;
							state_q <= ST_RD_O;
						end
					end
				end
				ST_RD_O: begin
					state_q <= ST_CAP_O;
				end
				ST_CAP_O: begin
					p_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						p_q <= p_q + NW'(1);
					end else if (!vld_s1 && !vld_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						out_idx_q     <= odf_pkg::OUT_IDX_W'(o_q);
						out_kept_q    <= !((o_cnt_q <= CW'(MAX_PRE)) && dom_q);
						out_ovf_q     <= ovf_q;
						out_last_q    <= o_final;
						if (o_final) begin
							n_q     <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							o_q     <= o_q + IW'(1);
							state_q <= ST_RD_O;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_axis_tdata = {out_ovf_q, out_kept_q, out_idx_q};
	assign m_axis_tlast = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/operator_dominance_filter.sv =====
// An accepted beat passes through the queue into the operator store while the
// engine is in its load state, one beat per cycle while beats arrive. After the
// beat with tlast, each stored operator is read and captured, scanned against
// every stored operator through the store's single read port, the compare and
// decide stages are drained, and its verdict is emitted; a stalled result holds it.
// Reset (arst_n low): queue emptied, set count and overflow cleared; store kept.
// ----------------------------------------------------------------------------
// operator_dominance_filter
// Loads a set of operators and reports, in load order, whether each one is
// dominated by another operator with the same effect.
// ----------------------------------------------------------------------------
`default_nettype none

module operator_dominance_filter #(
	parameter int MAX_OPS   = odf_pkg::DEF_MAX_OPS,
	parameter int MAX_PRE   = odf_pkg::DEF_MAX_PRE,
	parameter int PROP_BITS = odf_pkg::DEF_PROP_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// effect_id, pre_count, pre_a, pre_b, pre_c, pre_d, pre_e, op_cost
	input  wire logic [odf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  wire logic                            s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// op_index, kept, overflowed
	output logic [odf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                 m_axis_tlast
);

	localparam int PW    = odf_pkg::prop_w(PROP_BITS);
	localparam int REC_W = odf_pkg::store_w(MAX_PRE, PW) + 1;

	odf_pkg::q_status_t q_status;
	logic               q_push;
	logic               q_pop;
	logic [REC_W-1:0]   q_wdata;
	logic [REC_W-1:0]   q_rdata;

	odf_front #(
		.MAX_PRE   (MAX_PRE),
		.PROP_BITS (PROP_BITS)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	odf_fifo #(
		.W     (REC_W),
		.DEPTH (odf_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	odf_back #(
		.MAX_OPS   (MAX_OPS),
		.MAX_PRE   (MAX_PRE),
		.PROP_BITS (PROP_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/core/odf_checker.sv =====
// ----------------------------------------------------------------------------
// odf_checker
// Port-level checks on the result stream: ordering of indexes, overflow
// flag behavior and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module odf_checker #(
	parameter int MAX_OPS = odf_pkg::DEF_MAX_OPS
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [odf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic                            m_axis_tlast
);

	logic                          beat;
	logic [odf_pkg::OUT_IDX_W-1:0] exp_idx_q;
	logic                          ovf_q;

	assign beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			ovf_q     <= 1'b0;
		end else if (beat) begin
			exp_idx_q <= m_axis_tlast ? '0 : m_axis_tdata[5:0] + 6'd1;
			ovf_q     <= m_axis_tdata[7];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		beat |-> m_axis_tdata[5:0] == exp_idx_q)
		else $error("result index out of load order");

	a_ovf_run: assert property (@(posedge clk) disable iff (!arst_n)
		beat && (exp_idx_q != '0) |-> m_axis_tdata[7] == ovf_q)
		else $error("overflow flag changed within a set");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_axis_tlast && m_axis_tdata[7] |->
		m_axis_tdata[5:0] == odf_pkg::OUT_IDX_W'(MAX_OPS - 1))
		else $error("overflow reported on a set below capacity");

endmodule

bind operator_dominance_filter odf_checker #(
	.MAX_OPS (MAX_OPS)
) u_odf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// operator_dominance_filter testbench
// Streams operator sets into the filter and checks every keep/drop verdict.
// A predictor keeps its own copy of the current set. When a set closes, it
// queues one verdict per stored operator, and each result beat is checked
// against the oldest one. Directed sets cover cost and index ties, subsets,
// untestable counts, unsorted or repeated ids and the extreme values. Random
// sets follow: mostly small, a few full or overflowing, with random stalls
// on both sides.
// ----------------------------------------------------------------------------

module testbench;

	localparam int ITEMS = 430;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [5:0]       pad;
		logic [30:0]      cost;
		logic [4:0][15:0] pre;
		logic [2:0]       count;
		logic [15:0]      effect;
	} op_word_t;

	typedef struct packed {
		logic [5:0] index;
		logic       kept;
		logic       ovf;
		logic       last;
	} verdict_t;

	class dominance_board;
		logic [15:0]      eff  [odf_pkg::DEF_MAX_OPS];
		logic [2:0]       cnt  [odf_pkg::DEF_MAX_OPS];
		logic [4:0][15:0] pre  [odf_pkg::DEF_MAX_OPS];
		logic [30:0]      cost [odf_pkg::DEF_MAX_OPS];
		int               loaded;
		bit               ovf;
		verdict_t         due[$];
		int               mismatches;

		function bit testable(int i);
			return cnt[i] <= odf_pkg::DEF_MAX_PRE;
		endfunction

		// every precondition of a also appears in b
		function bit covers(int a, int b);
			bit hit;
			for (int i = 0; i < cnt[a]; i++) begin
				hit = 0;
				for (int j = 0; j < cnt[b]; j++)
					if (pre[b][j] == pre[a][i])
						hit = 1;
				if (!hit)
					return 0;
			end
			return 1;
		endfunction

		function bit beaten(int o);
			if (!testable(o))
				return 0;
			for (int p = 0; p < loaded; p++) begin
				if (p == o || !testable(p) || eff[p] != eff[o])
					continue;
				if (!covers(p, o))
					continue;
				if (covers(o, p)) begin
					if (cost[p] < cost[o] || (cost[p] == cost[o] && p < o))
						return 1;
				end else if (cost[p] <= cost[o]) begin
					return 1;
				end
			end
			return 0;
		endfunction

		function void load_operator(op_word_t w, bit last);
			verdict_t v;
			if (loaded < odf_pkg::DEF_MAX_OPS) begin
				eff[loaded]  = w.effect;
				cost[loaded] = w.cost;
				cnt[loaded]  = w.count;
				for (int i = 0; i < odf_pkg::DEF_MAX_PRE; i++)
					pre[loaded][i] = (w.count <= odf_pkg::DEF_MAX_PRE && i < w.count) ?
						w.pre[i] : '0;
				loaded++;
			end else begin
				ovf = 1;
			end
			if (!last)
				return;
			for (int i = 0; i < loaded; i++) begin
				v.index = i[5:0];
				v.kept  = !beaten(i);
				v.ovf   = ovf;
				v.last  = (i == loaded - 1);
				due = {due, v};
			end
			loaded = 0;
			ovf    = 0;
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			mismatches++;
		endtask

		task check_verdict(verdict_t got);
			verdict_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected result beat for operator %0d", got.index));
				return;
			end
			want = due.pop_front();
			if (got.index !== want.index)
				report($sformatf("op_index %0d, want %0d", got.index, want.index));
			if (got.kept !== want.kept)
				report($sformatf("op %0d kept %b, want %b", want.index, got.kept, want.kept));
			if (got.ovf !== want.ovf)
				report($sformatf("op %0d overflowed %b, want %b", want.index, got.ovf, want.ovf));
			if (got.last !== want.last)
				report($sformatf("op %0d tlast %b, want %b", want.index, got.last, want.last));
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// effect_id, pre_count, pre_a, pre_b, pre_c, pre_d, pre_e, op_cost
	logic [odf_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                           s_axis_tlast  = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// op_index, kept, overflowed
	logic [odf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tlast;

	dominance_board board;
	int             sent   = 0;
	bit             idling = 1'b1;
	bit             calm   = 1'b0;
	int             stall  = 0;

	operator_dominance_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// result sink with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stall > 0)
				stall--;
			else if (idling && !calm && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 4);
			m_axis_tready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_verdict({m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[7],
				m_axis_tlast});
	end

	function automatic op_word_t make_op(logic [15:0] effect, logic [2:0] count,
		logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
		logic [15:0] e, logic [30:0] cost);
		op_word_t w;
		w        = '0;
		w.effect = effect;
		w.count  = count;
		w.pre    = {e, d, c, b, a};
		w.cost   = cost;
		return w;
	endfunction

	// ids come from a window of seven starting at id_base, so subsets and equal
	// sets are common; wild items use a fully random effect
	function automatic op_word_t random_op(logic [15:0] eff_base, int eff_span,
		logic [15:0] id_base, bit wild);
		op_word_t    w;
		logic [6:0]  pick;
		logic [15:0] t;
		int          n;
		int          a;
		int          b;
		w = '0;
		for (int i = 0; i < 5; i++)
			w.pre[i] = 16'($urandom);
		w.effect = wild ? 16'($urandom) : eff_base + 16'($urandom_range(0, eff_span - 1));
		if ($urandom_range(0, 9) == 0) begin
			w.count = 3'($urandom_range(6, 7));
		end else begin
			do
				pick = 7'($urandom);
			while ($countones(pick) > 5);
			n = 0;
			for (int k = 0; k < 7; k++)
				if (pick[k]) begin
					w.pre[n] = id_base + 16'(k);
					n++;
				end
			w.count = 3'(n);
			if (n > 1 && $urandom_range(0, 5) == 0) begin
				a = $urandom_range(0, n - 1);
				b = $urandom_range(0, n - 1);
				if ($urandom_range(0, 1)) begin
					t        = w.pre[a];
					w.pre[a] = w.pre[b];
					w.pre[b] = t;
				end else begin
					w.pre[a] = w.pre[b];
				end
			end
		end
		case ($urandom_range(0, 9))
			0: w.cost = 31'($urandom);
			1: w.cost = 31'h7FFFFFFF - 31'($urandom_range(0, 3));
			default: w.cost = 31'($urandom_range(0, 6));
		endcase
		return w;
	endfunction

	task automatic send_op(op_word_t w, bit last);
		if (idling && !calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.load_operator(w, last);
		sent++;
	endtask

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("operator_dominance_filter test failed");
		$finish;
	end

	initial begin
		int          r;
		int          size;
		int          eff_span;
		logic [15:0] eff_base;
		logic [15:0] id_base;

		board = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal sets tied on cost, strict superset, costlier subset
		send_op(make_op(16'hFFFF, 2, 1, 2, 0, 0, 0, 5), 0);
		send_op(make_op(16'hFFFF, 2, 1, 2, 0, 0, 0, 5), 0);
		send_op(make_op(16'hFFFF, 3, 1, 2, 3, 0, 0, 5), 0);
		send_op(make_op(16'hFFFF, 1, 2, 0, 0, 0, 0, 6), 1);
		// untestable counts, unsorted and repeated ids, extreme values
		send_op(make_op(16'h0000, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			31'h7FFFFFFF), 0);
		send_op(make_op(16'h0000, 6, 1, 2, 3, 4, 5, 31'h7FFFFFFF), 0);
		send_op(make_op(16'h0000, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			0), 0);
		send_op(make_op(16'h0000, 3, 16'hFFFF, 0, 16'h8000, 0, 0, 31'h7FFFFFFF), 0);
		send_op(make_op(16'h0000, 5, 7, 7, 3, 3, 7, 0), 0);
		send_op(make_op(16'h0000, 2, 3, 7, 0, 0, 0, 0), 0);
		send_op(make_op(16'h0001, 0, 0, 0, 0, 0, 0, 0), 1);
		// lone operator
		send_op(make_op(16'h8001, 5, 16'hFFFB, 16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF,
			0), 1);
		// cheaper duplicate and costlier subset
		send_op(make_op(16'h1234, 1, 10, 0, 0, 0, 0, 100), 0);
		send_op(make_op(16'h1234, 2, 10, 11, 0, 0, 0, 50), 0);
		send_op(make_op(16'h1234, 1, 10, 0, 0, 0, 0, 99), 0);
		send_op(make_op(16'h1234, 1, 10, 0, 0, 0, 0, 99), 1);

		while (sent < ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				size = odf_pkg::DEF_MAX_OPS;
			else if (r == 1)
				size = odf_pkg::DEF_MAX_OPS + $urandom_range(1, 4);
			else
				size = $urandom_range(1, 10);
			eff_base = 16'($urandom);
			eff_span = $urandom_range(1, 3);
			id_base  = 16'($urandom);
			idling   = ($urandom_range(0, 4) != 0);
			for (int k = 0; k < size; k++)
				send_op(random_op(eff_base, eff_span, id_base, $urandom_range(0, 15) == 0),
					k == size - 1);
			if (sent >= ITEMS - 60)
				calm = 1'b1;
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0)
			$display("operator_dominance_filter test passed");
		else
			$display("operator_dominance_filter test failed");
		$finish;
	end

endmodule

// ===== operator_dominance_filter.f =====
rtl/core/odf_pkg.sv
rtl/core/odf_front.sv
rtl/core/odf_fifo.sv
rtl/core/odf_back.sv
rtl/core/operator_dominance_filter.sv
rtl/core/odf_checker.sv
tb/testbench.sv
